// File: sv/bmbs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmbs_pkg: shared constants of the Boyer-Moore byte search block
// Sizes of the pattern and text stores and the widths derived from them.
// ----------------------------------------------------------------------------
package bmbs_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int MAX_TEXT    = 4096;
  localparam int ALPHABET    = 256;

  // Width of a byte and of a bad-character table address.
  localparam int BYTE_W = $clog2(ALPHABET);
  // Pattern numbers: positions, lengths, shifts and border positions up to m + 1.
  localparam int PW     = $clog2(MAX_PATTERN + 2);
  // Index into the pattern store.
  localparam int PIW    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  // Text length (can hold MAX_TEXT itself) and text store index.
  localparam int TLW    = $clog2(MAX_TEXT + 1);
  localparam int TIW    = $clog2(MAX_TEXT);
  // Fixed width of the reported match position.
  localparam int POS_W  = 12;

  // Depth of the good-suffix and border tables (positions 0 .. m + 1).
  localparam int GS_DEPTH = MAX_PATTERN + 2;

  // Input function codes.
  localparam logic FUNC_PATTERN = 1'b0;
  localparam logic FUNC_TEXT    = 1'b1;

endpackage : bmbs_pkg
`default_nettype wire

// File: sv/boyer_moore_byte_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// boyer_moore_byte_search: Boyer-Moore search over a stored byte text
// Stores pattern and text bytes, builds the bad-character and strong
// good-suffix tables in memory, and searches with the larger of both shifts.
// ----------------------------------------------------------------------------
// Usage. A request is accepted on a rising edge with start high and busy low.
// in_func selects a pattern byte or a text byte, in_data_byte carries it and
// in_last closes the pattern or the text. Ordinary bytes are written to their
// store at one request per cycle; busy stays low between them.
// A closing pattern byte raises busy while the tables are built: a sweep
// clears the bad-character table, a pass fills it, a second sweep clears the
// good-suffix table, the border scan runs, and a final pass completes the
// good-suffix table.
// A closing text byte raises busy for the search: each alignment is checked
// and compared right to left and then shifted; finally out_valid pulses for a
// single cycle with out_found, out_position and out_overflow. The
// receiver cannot stall and must take the result in that cycle. Busy falls in
// the cycle after the strobe. Bytes past capacity are dropped and flagged in
// out_overflow. The pattern and its tables stay for further searches.
// Reset (synchronous, active low) forgets any pattern and text; the memories
// are not cleared, since nothing is read before it is written.
// ----------------------------------------------------------------------------
module boyer_moore_byte_search
  import bmbs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic             in_func,
  input  wire logic [BYTE_W-1:0] in_data_byte,
  input  wire logic             in_last,
  output logic                  out_valid,
  output logic                  out_found,
  output logic [POS_W-1:0]      out_position,
  output logic                  out_overflow
);

  // Sequencer states.
  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_BC_CLR = 5'd1;
  localparam logic [4:0] ST_BC_RD  = 5'd2;
  localparam logic [4:0] ST_BC_WR  = 5'd3;
  localparam logic [4:0] ST_GS_CLR = 5'd4;
  localparam logic [4:0] ST_OUTER  = 5'd5;
  localparam logic [4:0] ST_CMP    = 5'd6;
  localparam logic [4:0] ST_GS     = 5'd7;
  localparam logic [4:0] ST_P2_RD0 = 5'd8;
  localparam logic [4:0] ST_P2_J   = 5'd9;
  localparam logic [4:0] ST_P2_RD  = 5'd10;
  localparam logic [4:0] ST_P2_WR  = 5'd11;
  localparam logic [4:0] ST_SR_CHK = 5'd12;
  localparam logic [4:0] ST_SR_RD  = 5'd13;
  localparam logic [4:0] ST_SR_CMP = 5'd14;
  localparam logic [4:0] ST_SR_SH  = 5'd15;
  localparam logic [4:0] ST_DONE   = 5'd16;

  // Memories. The pattern is kept twice so that the border scan can read two
  // positions in one cycle.
  logic [BYTE_W-1:0] pat_a_mem [MAX_PATTERN];
  logic [BYTE_W-1:0] pat_b_mem [MAX_PATTERN];
  logic [BYTE_W-1:0] text_mem  [MAX_TEXT];
  logic [PW-1:0]     bc_mem    [ALPHABET];
  logic [PW-1:0]     gs_mem    [GS_DEPTH];
  logic [PW-1:0]     pre_mem   [GS_DEPTH];

  // Control and counters.
  logic [4:0]        state_r, state_nxt;
  logic [PW-1:0]     plen_r, plen_nxt;
  logic [TLW-1:0]    tlen_r, tlen_nxt;
  logic              ovf_seen_r, ovf_seen_nxt;
  logic              closed_r, closed_nxt;
  logic              trunc_r, trunc_nxt;
  logic [PW-1:0]     i_r, i_nxt;
  logic [PW-1:0]     j_r, j_nxt;
  logic [PW-1:0]     k_r, k_nxt;
  logic [TLW-1:0]    s_r, s_nxt;
  logic [BYTE_W-1:0] bcc_r, bcc_nxt;
  logic              found_r, found_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;

  // Memory port controls.
  logic              pat_we;
  logic [PIW-1:0]    pat_wa;
  logic              text_we;
  logic [TIW-1:0]    text_wa;
  logic              bc_we;
  logic [BYTE_W-1:0] bc_wa;
  logic [PW-1:0]     bc_wd;
  logic              gs_we;
  logic [PW-1:0]     gs_wa, gs_wd;
  logic              pre_we;
  logic [PW-1:0]     pre_wa, pre_wd;

  logic [PIW-1:0]    pa_ra, pb_ra;
  logic [TIW-1:0]    text_ra;
  logic [BYTE_W-1:0] bc_ra;
  logic [PW-1:0]     gs_ra, pre_ra;

  logic [BYTE_W-1:0] pa_q, pb_q, text_q;
  logic [PW-1:0]     bc_q, gs_q, pre_q;

  // Helpers.
  logic              accept;
  logic [PW-1:0]     eff_plen;
  logic [PW-1:0]     i_m1, j_m1, k_m1, shift;
  logic [TLW:0]      s_plus_m;
  logic [TLW:0]      text_addr;

  assign accept    = start && !busy;
  assign eff_plen  = closed_r ? '0 : plen_r;
  assign i_m1      = i_r - PW'(1);
  assign j_m1      = j_r - PW'(1);
  assign k_m1      = k_r - PW'(1);
  assign s_plus_m  = {1'b0, s_r} + (TLW+1)'(plen_r);
  assign text_addr = {1'b0, s_r} + (TLW+1)'(k_m1);

  always_comb begin
    shift = gs_q;
    if ((bc_q < k_r) && ((k_r - bc_q) > gs_q)) begin
      shift = k_r - bc_q;
    end
    if (shift == '0) begin
      shift = PW'(1);
    end
  end

  always_comb begin
    state_nxt    = state_r;
    plen_nxt     = plen_r;
    tlen_nxt     = tlen_r;
    ovf_seen_nxt = ovf_seen_r;
    closed_nxt   = closed_r;
    trunc_nxt    = trunc_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    s_nxt        = s_r;
    bcc_nxt      = bcc_r;
    found_nxt    = found_r;
    pos_nxt      = pos_r;

    pat_we  = 1'b0;
    pat_wa  = eff_plen[PIW-1:0];
    text_we = 1'b0;
    text_wa = tlen_r[TIW-1:0];
    bc_we   = 1'b0;
    bc_wa   = bcc_r;
    bc_wd   = '0;
    gs_we   = 1'b0;
    gs_wa   = i_r;
    gs_wd   = '0;
    pre_we  = 1'b0;
    pre_wa  = i_m1;
    pre_wd  = j_m1;

    pa_ra   = i_r[PIW-1:0];
    pb_ra   = j_m1[PIW-1:0];
    text_ra = text_addr[TIW-1:0];
    bc_ra   = text_q;
    gs_ra   = j_r;
    pre_ra  = j_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_PATTERN) begin
            if (closed_r) begin
              closed_nxt = 1'b0;
              trunc_nxt  = 1'b0;
            end
            if (eff_plen < PW'(MAX_PATTERN)) begin
              pat_we   = 1'b1;
              plen_nxt = eff_plen + PW'(1);
            end else begin
              plen_nxt  = eff_plen;
              trunc_nxt = 1'b1;
            end
            if (in_last) begin
              bcc_nxt   = '0;
              state_nxt = ST_BC_CLR;
            end
          end else begin
            if (tlen_r < TLW'(MAX_TEXT)) begin
              text_we  = 1'b1;
              tlen_nxt = tlen_r + TLW'(1);
            end else begin
              ovf_seen_nxt = 1'b1;
            end
            if (in_last) begin
              s_nxt     = '0;
              state_nxt = ST_SR_CHK;
            end
          end
        end
      end

      // Clear the bad-character table, one entry per cycle.
      ST_BC_CLR: begin
        bc_we   = 1'b1;
        bc_wa   = bcc_r;
        bc_wd   = '0;
        bcc_nxt = bcc_r + BYTE_W'(1);
        if (bcc_r == '1) begin
          i_nxt     = '0;
          state_nxt = ST_BC_RD;
        end
      end

      ST_BC_RD: begin
        pa_ra = i_r[PIW-1:0];
        if (i_r == plen_r) begin
          i_nxt     = '0;
          state_nxt = ST_GS_CLR;
        end else begin
          state_nxt = ST_BC_WR;
        end
      end

      ST_BC_WR: begin
        bc_we     = 1'b1;
        bc_wa     = pa_q;
        bc_wd     = i_r + PW'(1);
        i_nxt     = i_r + PW'(1);
        state_nxt = ST_BC_RD;
      end

      // Zero the good-suffix entries 0..m and seed the border of position m.
      ST_GS_CLR: begin
        gs_we  = 1'b1;
        gs_wa  = i_r;
        gs_wd  = '0;
        pre_we = 1'b1;
        pre_wa = plen_r;
        pre_wd = plen_r + PW'(1);
        i_nxt  = i_r + PW'(1);
        if (i_r == plen_r) begin
          i_nxt     = plen_r;
          j_nxt     = plen_r + PW'(1);
          state_nxt = ST_OUTER;
        end
      end

      // Border scan: compare pattern[i-1] with pattern[j-1] while j <= m.
      ST_OUTER: begin
        pa_ra = i_m1[PIW-1:0];
        pb_ra = j_m1[PIW-1:0];
        if (i_r == '0) begin
          state_nxt = ST_P2_RD0;
        end else if (j_r <= plen_r) begin
          state_nxt = ST_CMP;
        end else begin
          pre_we = 1'b1;
          i_nxt  = i_m1;
          j_nxt  = j_m1;
        end
      end

      ST_CMP: begin
        gs_ra  = j_r;
        pre_ra = j_r;
        if (pa_q != pb_q) begin
          state_nxt = ST_GS;
        end else begin
          pre_we    = 1'b1;
          i_nxt     = i_m1;
          j_nxt     = j_m1;
          state_nxt = ST_OUTER;
        end
      end

      ST_GS: begin
        if (gs_q == '0) begin
          gs_we = 1'b1;
          gs_wa = j_r;
          gs_wd = j_r - i_r;
        end
        j_nxt     = pre_q;
        state_nxt = ST_OUTER;
      end

      // Final pass: fill remaining good-suffix entries from the border chain.
      ST_P2_RD0: begin
        pre_ra    = '0;
        state_nxt = ST_P2_J;
      end

      ST_P2_J: begin
        j_nxt     = pre_q;
        i_nxt     = '0;
        state_nxt = ST_P2_RD;
      end

      ST_P2_RD: begin
        gs_ra     = i_r;
        pre_ra    = j_r;
        state_nxt = ST_P2_WR;
      end

      ST_P2_WR: begin
        if (gs_q == '0) begin
          gs_we = 1'b1;
          gs_wa = i_r;
          gs_wd = j_r;
        end
        if (i_r == j_r) begin
          j_nxt = pre_q;
        end
        if (i_r == plen_r) begin
          closed_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          i_nxt     = i_r + PW'(1);
          state_nxt = ST_P2_RD;
        end
      end

      // Search: check the alignment s fits, then compare right to left.
      ST_SR_CHK: begin
        k_nxt = plen_r;
        if (!closed_r || (plen_r == '0) || (s_plus_m > {1'b0, tlen_r})) begin
          found_nxt = 1'b0;
          pos_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_SR_RD;
        end
      end

      ST_SR_RD: begin
        pa_ra     = k_m1[PIW-1:0];
        text_ra   = text_addr[TIW-1:0];
        state_nxt = ST_SR_CMP;
      end

      ST_SR_CMP: begin
        gs_ra = k_r;
        bc_ra = text_q;
        if (pa_q == text_q) begin
          if (k_r == PW'(1)) begin
            found_nxt = 1'b1;
            pos_nxt   = POS_W'(s_r);
            state_nxt = ST_DONE;
          end else begin
            k_nxt     = k_m1;
            state_nxt = ST_SR_RD;
          end
        end else begin
          state_nxt = ST_SR_SH;
        end
      end

      ST_SR_SH: begin
        s_nxt     = s_r + TLW'(shift);
        state_nxt = ST_SR_CHK;
      end

      ST_DONE: begin
        tlen_nxt     = '0;
        ovf_seen_nxt = 1'b0;
        state_nxt    = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      plen_r     <= '0;
      tlen_r     <= '0;
      ovf_seen_r <= 1'b0;
      closed_r   <= 1'b0;
      trunc_r    <= 1'b0;
      found_r    <= 1'b0;
      pos_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      plen_r     <= plen_nxt;
      tlen_r     <= tlen_nxt;
      ovf_seen_r <= ovf_seen_nxt;
      closed_r   <= closed_nxt;
      trunc_r    <= trunc_nxt;
      found_r    <= found_nxt;
      pos_r      <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
    s_r   <= s_nxt;
    bcc_r <= bcc_nxt;
  end

  // Synchronous memories, one write and one registered read each.
  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_a_mem[pat_wa] <= in_data_byte;
      pat_b_mem[pat_wa] <= in_data_byte;
    end
    pa_q <= pat_a_mem[pa_ra];
    pb_q <= pat_b_mem[pb_ra];
  end

  always_ff @(posedge clk) begin
    if (text_we) begin
      text_mem[text_wa] <= in_data_byte;
    end
    text_q <= text_mem[text_ra];
  end

  always_ff @(posedge clk) begin
    if (bc_we) begin
      bc_mem[bc_wa] <= bc_wd;
    end
    bc_q <= bc_mem[bc_ra];
  end

  always_ff @(posedge clk) begin
    if (gs_we) begin
      gs_mem[gs_wa] <= gs_wd;
    end
    gs_q <= gs_mem[gs_ra];
  end

  always_ff @(posedge clk) begin
    if (pre_we) begin
      pre_mem[pre_wa] <= pre_wd;
    end
    pre_q <= pre_mem[pre_ra];
  end

  assign busy         = (state_r != ST_IDLE);
  assign out_valid    = (state_r == ST_DONE);
  assign out_found    = found_r;
  assign out_position = pos_r;
  assign out_overflow = ovf_seen_r | trunc_r;

  // A result strobe lasts one cycle and the block is free right after it.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle");

  // A miss reports position zero.
  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_position == '0))
    else $error("miss with nonzero position");

  // A closing text request always starts a search.
  a_search_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func == FUNC_TEXT) && in_last) |=> busy)
    else $error("search did not start");

  // The pattern length never exceeds capacity.
  a_plen_cap: assert property (@(posedge clk) disable iff (!rst_n)
    plen_r <= PW'(MAX_PATTERN))
    else $error("pattern length beyond capacity");

endmodule : boyer_moore_byte_search
`default_nettype wire
